// ===== hw/rtl/fssh_pkg.sv =====
// ----------------------------------------------------------------------------
// FIX session heartbeat package
// Codes, item and result types, and sizing constants shared by the block.
// ----------------------------------------------------------------------------
package fssh_pkg;

   localparam int INQ_DEPTH   = 4;
   localparam int MAX_RESULTS = 4;

   localparam logic [11:0] TIMER_MAX     = 12'd4095;
   localparam logic [11:0] HB_SECS_RESET = 12'd30;

   // Configuration register indexes.
   localparam logic CSR_HEARTBEAT_SECONDS   = 1'b0;
   localparam logic CSR_WEEKLY_RESET_ENABLE = 1'b1;

   // Actions.
   localparam logic [2:0] ACT_START     = 3'd0;
   localparam logic [2:0] ACT_LINK_UP   = 3'd1;
   localparam logic [2:0] ACT_LINK_FAIL = 3'd2;
   localparam logic [2:0] ACT_LINK_DOWN = 3'd3;
   localparam logic [2:0] ACT_STOP      = 3'd4;
   localparam logic [2:0] ACT_TICK      = 3'd5;
   localparam logic [2:0] ACT_MESSAGE   = 3'd6;

   // Inbound message kinds.
   localparam logic [2:0] MSG_LOGON     = 3'd0;
   localparam logic [2:0] MSG_LOGOUT    = 3'd1;
   localparam logic [2:0] MSG_HEARTBEAT = 3'd2;
   localparam logic [2:0] MSG_TEST_REQ  = 3'd3;
   localparam logic [2:0] MSG_RESEND    = 3'd4;
   localparam logic [2:0] MSG_SEQ_RESET = 3'd5;
   localparam logic [2:0] MSG_APP       = 3'd6;

   // Session phases.
   localparam logic [2:0] PH_DISC        = 3'd0;
   localparam logic [2:0] PH_CONN        = 3'd1;
   localparam logic [2:0] PH_LOGON_SENT  = 3'd2;
   localparam logic [2:0] PH_LOGGED_ON   = 3'd3;
   localparam logic [2:0] PH_LOGOUT_SENT = 3'd4;
   localparam logic [2:0] PH_ERROR       = 3'd5;

   // Result event kinds.
   localparam logic [3:0] EV_LOGON       = 4'd0;
   localparam logic [3:0] EV_LOGOUT      = 4'd1;
   localparam logic [3:0] EV_HB          = 4'd2;
   localparam logic [3:0] EV_ECHO        = 4'd3;
   localparam logic [3:0] EV_TEST        = 4'd4;
   localparam logic [3:0] EV_DISC        = 4'd5;
   localparam logic [3:0] EV_GAP         = 4'd6;
   localparam logic [3:0] EV_LOGON_ACK   = 4'd7;
   localparam logic [3:0] EV_LOGOUT_NOTE = 4'd8;
   localparam logic [3:0] EV_APP         = 4'd9;
   localparam logic [3:0] EV_REJECT      = 4'd10;
   localparam logic [3:0] EV_NONE        = 4'd11;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  msg_kind;
      logic        seq_present;
      logic [31:0] inbound_seq_value;
      logic        test_id_present;
      logic        new_seq_present;
      logic [31:0] new_seq_value;
      logic        in_weekly_window;
   } item_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [31:0] assigned_seq;
      logic [31:0] expected_seq;
      logic [2:0]  session_phase;
      logic        last_of_run;
   } result_type;

   function automatic result_type make_result(logic [3:0] kind, logic [31:0] aseq,
                                              logic [31:0] eseq, logic [2:0] ph);
      result_type r;
      r.event_kind    = kind;
      r.assigned_seq  = aseq;
      r.expected_seq  = eseq;
      r.session_phase = ph;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   function automatic logic [11:0] sat_inc(logic [11:0] v);
      return (v == TIMER_MAX) ? TIMER_MAX : v + 12'd1;
   endfunction

endpackage

// ===== hw/rtl/fssh_inq.sv =====
// ----------------------------------------------------------------------------
// FIX session heartbeat input queue
// Small first-in first-out store that takes items from the requester and
// hands the oldest one to the session engine.
// ----------------------------------------------------------------------------
module fssh_inq #(
   parameter int DEPTH = fssh_pkg::INQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fssh_pkg::item_type push_item,
   output logic               full,
   output logic               head_valid,
   output fssh_pkg::item_type head_item,
   input  logic               take
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   fssh_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_take;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = take && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_take) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_take) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/fssh_engine.sv =====
// ----------------------------------------------------------------------------
// FIX session heartbeat engine
// Holds the session state, works one item at a time into a run of up to four
// results and hands those results out one per cycle while rsp_pop is high.
// ----------------------------------------------------------------------------
module fssh_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [11:0]          csr_write_data,
   input  logic                 item_valid,
   input  fssh_pkg::item_type   item,
   output logic                 item_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fssh_pkg::result_type rsp_result
);

   // Configuration.
   logic [11:0] hb_secs_ff;
   logic        weekly_en_ff;

   // Session state.
   logic [2:0]  phase_ff, phase_in;
   logic        link_ff, link_in;
   logic [31:0] in_exp_ff, in_exp_in;
   logic [31:0] out_next_ff, out_next_in;
   logic [11:0] idle_send_ff, idle_send_in;
   logic [11:0] idle_recv_ff, idle_recv_in;
   logic [11:0] test_wait_ff, test_wait_in;
   logic        test_out_ff, test_out_in;

   // Result run buffer.
   fssh_pkg::result_type res_ff [fssh_pkg::MAX_RESULTS];
   fssh_pkg::result_type res_in [fssh_pkg::MAX_RESULTS];
   logic [2:0] res_cnt_ff, res_cnt_in;
   logic [1:0] rd_idx_ff, rd_idx_in;

   logic pop_ok, run_done;

   assign rsp_empty  = (res_cnt_ff == 3'd0);
   assign rsp_result = res_ff[rd_idx_ff];
   assign pop_ok     = rsp_pop && !rsp_empty;
   assign run_done   = pop_ok && ({1'b0, rd_idx_ff} == res_cnt_ff - 3'd1);
   // A new item may start as the last result of the current run leaves.
   assign item_take  = item_valid && (rsp_empty || run_done);

   always_comb begin
      logic [2:0] n;
      logic [1:0] li;
      phase_in     = phase_ff;
      link_in      = link_ff;
      in_exp_in    = in_exp_ff;
      out_next_in  = out_next_ff;
      idle_send_in = idle_send_ff;
      idle_recv_in = idle_recv_ff;
      test_wait_in = test_wait_ff;
      test_out_in  = test_out_ff;
      res_in       = res_ff;
      n            = 3'd0;

      case (item.action)
         fssh_pkg::ACT_START: begin
            if (phase_ff != fssh_pkg::PH_DISC) begin
               res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_REJECT, '0, '0, phase_in);
               n = n + 3'd1;
            end else begin
               phase_in = fssh_pkg::PH_CONN;
               if (weekly_en_ff && item.in_weekly_window) begin
                  out_next_in = 32'd1;
                  in_exp_in   = 32'd1;
               end
               idle_send_in = '0;
               idle_recv_in = '0;
               test_wait_in = '0;
               test_out_in  = 1'b0;
            end
         end
         fssh_pkg::ACT_LINK_UP: begin
            if (phase_ff == fssh_pkg::PH_CONN) begin
               link_in  = 1'b1;
               phase_in = fssh_pkg::PH_LOGON_SENT;
               res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGON, out_next_in, '0,
                                                      phase_in);
               n = n + 3'd1;
               out_next_in  = out_next_in + 32'd1;
               idle_send_in = '0;
            end
         end
         fssh_pkg::ACT_LINK_FAIL: begin
            if (phase_ff == fssh_pkg::PH_CONN) begin
               link_in  = 1'b0;
               phase_in = fssh_pkg::PH_ERROR;
            end
         end
         fssh_pkg::ACT_LINK_DOWN: begin
            link_in  = 1'b0;
            phase_in = fssh_pkg::PH_DISC;
            res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGOUT_NOTE, '0, '0, phase_in);
            n = n + 3'd1;
         end
         fssh_pkg::ACT_STOP: begin
            if (phase_in == fssh_pkg::PH_LOGGED_ON || phase_in == fssh_pkg::PH_LOGON_SENT) begin
               phase_in = fssh_pkg::PH_LOGOUT_SENT;
               if (link_in) begin
                  res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGOUT, out_next_in,
                                                         '0, phase_in);
                  n = n + 3'd1;
                  out_next_in  = out_next_in + 32'd1;
                  idle_send_in = '0;
               end
            end
            link_in  = 1'b0;
            phase_in = fssh_pkg::PH_DISC;
            res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_DISC, '0, '0, phase_in);
            n = n + 3'd1;
         end
         fssh_pkg::ACT_TICK: begin
            idle_send_in = fssh_pkg::sat_inc(idle_send_ff);
            idle_recv_in = fssh_pkg::sat_inc(idle_recv_ff);
            if (test_out_ff) begin
               test_wait_in = fssh_pkg::sat_inc(test_wait_ff);
            end
            if (link_ff && phase_ff == fssh_pkg::PH_LOGGED_ON) begin
               if (idle_send_in >= hb_secs_ff) begin
                  res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_HB, out_next_in, '0,
                                                         phase_in);
                  n = n + 3'd1;
                  out_next_in  = out_next_in + 32'd1;
                  idle_send_in = '0;
               end
               if (idle_recv_in >= hb_secs_ff && !test_out_in) begin
                  test_out_in  = 1'b1;
                  test_wait_in = '0;
                  res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_TEST, out_next_in, '0,
                                                         phase_in);
                  n = n + 3'd1;
                  out_next_in  = out_next_in + 32'd1;
                  idle_send_in = '0;
               end
               // Test request timed out: the session is stopped from logged on.
               if (test_out_in && test_wait_in >= hb_secs_ff) begin
                  phase_in = fssh_pkg::PH_LOGOUT_SENT;
                  res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGOUT, out_next_in,
                                                         '0, phase_in);
                  n = n + 3'd1;
                  out_next_in  = out_next_in + 32'd1;
                  idle_send_in = '0;
                  link_in  = 1'b0;
                  phase_in = fssh_pkg::PH_DISC;
                  res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_DISC, '0, '0, phase_in);
                  n = n + 3'd1;
               end
            end
         end
         fssh_pkg::ACT_MESSAGE: begin
            if (link_ff) begin
               idle_recv_in = '0;
               if (item.seq_present) begin
                  if (item.inbound_seq_value > in_exp_ff) begin
                     res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_GAP, '0, in_exp_ff,
                                                            phase_in);
                     n = n + 3'd1;
                  end else if (item.inbound_seq_value == in_exp_ff) begin
                     in_exp_in = in_exp_ff + 32'd1;
                  end
               end
               case (item.msg_kind)
                  fssh_pkg::MSG_LOGON: begin
                     phase_in = fssh_pkg::PH_LOGGED_ON;
                     res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGON_ACK, '0, '0,
                                                            phase_in);
                     n = n + 3'd1;
                  end
                  fssh_pkg::MSG_LOGOUT: begin
                     res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGOUT_NOTE, '0,
                                                            '0, phase_in);
                     n = n + 3'd1;
                     if (phase_in == fssh_pkg::PH_LOGGED_ON ||
                         phase_in == fssh_pkg::PH_LOGON_SENT) begin
                        phase_in = fssh_pkg::PH_LOGOUT_SENT;
                        res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_LOGOUT,
                                                               out_next_in, '0, phase_in);
                        n = n + 3'd1;
                        out_next_in  = out_next_in + 32'd1;
                        idle_send_in = '0;
                     end
                     link_in  = 1'b0;
                     phase_in = fssh_pkg::PH_DISC;
                     res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_DISC, '0, '0,
                                                            phase_in);
                     n = n + 3'd1;
                  end
                  fssh_pkg::MSG_HEARTBEAT: begin
                     if (item.test_id_present) begin
                        test_out_in = 1'b0;
                     end
                  end
                  fssh_pkg::MSG_TEST_REQ: begin
                     res_in[n[1:0]] = fssh_pkg::make_result(
                        item.test_id_present ? fssh_pkg::EV_ECHO : fssh_pkg::EV_HB,
                        out_next_in, '0, phase_in);
                     n = n + 3'd1;
                     out_next_in  = out_next_in + 32'd1;
                     idle_send_in = '0;
                  end
                  fssh_pkg::MSG_RESEND: begin
                  end
                  fssh_pkg::MSG_SEQ_RESET: begin
                     if (item.new_seq_present) begin
                        in_exp_in = item.new_seq_value;
                     end
                  end
                  default: begin
                     res_in[n[1:0]] = fssh_pkg::make_result(fssh_pkg::EV_APP, '0, '0,
                                                            phase_in);
                     n = n + 3'd1;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      if (n == 3'd0) begin
         res_in[0] = fssh_pkg::make_result(fssh_pkg::EV_NONE, '0, '0, phase_in);
         n = 3'd1;
      end
      li = 2'(n - 3'd1);
      res_in[li].last_of_run = 1'b1;
      res_cnt_in = n;
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (pop_ok) begin
         rd_idx_in = run_done ? 2'd0 : rd_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_ff <= res_in;
      end
      if (reset) begin
         hb_secs_ff   <= fssh_pkg::HB_SECS_RESET;
         weekly_en_ff <= 1'b0;
         phase_ff     <= fssh_pkg::PH_DISC;
         link_ff      <= 1'b0;
         in_exp_ff    <= 32'd1;
         out_next_ff  <= 32'd1;
         idle_send_ff <= '0;
         idle_recv_ff <= '0;
         test_wait_ff <= '0;
         test_out_ff  <= 1'b0;
         res_cnt_ff   <= 3'd0;
         rd_idx_ff    <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == fssh_pkg::CSR_HEARTBEAT_SECONDS) begin
               hb_secs_ff <= csr_write_data;
            end else if (csr_index == fssh_pkg::CSR_WEEKLY_RESET_ENABLE) begin
               weekly_en_ff <= csr_write_data[0];
            end
         end
         if (item_take) begin
            phase_ff     <= phase_in;
            link_ff      <= link_in;
            in_exp_ff    <= in_exp_in;
            out_next_ff  <= out_next_in;
            idle_send_ff <= idle_send_in;
            idle_recv_ff <= idle_recv_in;
            test_wait_ff <= test_wait_in;
            test_out_ff  <= test_out_in;
            res_cnt_ff   <= res_cnt_in;
            rd_idx_ff    <= 2'd0;
         end else begin
            if (run_done) begin
               res_cnt_ff <= 3'd0;
            end
            rd_idx_ff <= rd_idx_in;
         end
      end
   end

endmodule

// ===== hw/rtl/fix_session_state_heartbeat_top.sv =====
// ----------------------------------------------------------------------------
// FIX session state and heartbeat controller
// Session-layer supervision of one FIX link: phases, sequence numbers,
// heartbeats and test requests.
// ----------------------------------------------------------------------------
// Usage:
// Items (events and parsed inbound messages) are pushed on the req_ side
// while req_full is low; they wait in a small queue of INQ_DEPTH entries.
// Each item produces a run of one to four results, read on the rsp_ side
// like a queue: the oldest result shows while rsp_empty is low and leaves
// when rsp_pop is high. rsp_last_of_run marks the final result of a run.
// An item pushed into an empty block is first written into the input
// queue, then taken by the engine, whose result register shows its first
// result. The engine works one item per run and hands out one result per
// cycle while rsp_pop is high; the next run starts in the cycle the last
// result of the previous run is popped.
// When the receiver stalls, results hold and the input queue keeps taking
// items until it is full. Reset is synchronous and empties both sides,
// returns the session to disconnected with both sequence counters at one
// and the heartbeat interval at 30 seconds. csr_ writes are registered.
// ----------------------------------------------------------------------------
module fix_session_state_heartbeat_top #(
   parameter int INQ_DEPTH = fssh_pkg::INQ_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [11:0] csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_msg_kind,
   input  logic        req_seq_present,
   input  logic [31:0] req_inbound_seq_value,
   input  logic        req_test_id_present,
   input  logic        req_new_seq_present,
   input  logic [31:0] req_new_seq_value,
   input  logic        req_in_weekly_window,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_event_kind,
   output logic [31:0] rsp_assigned_seq,
   output logic [31:0] rsp_expected_seq,
   output logic [2:0]  rsp_session_phase,
   output logic        rsp_last_of_run
);

   fssh_pkg::item_type   push_item;
   fssh_pkg::item_type   head_item;
   fssh_pkg::result_type result;
   logic                 head_valid;
   logic                 take;

   assign push_item.action            = req_action;
   assign push_item.msg_kind          = req_msg_kind;
   assign push_item.seq_present       = req_seq_present;
   assign push_item.inbound_seq_value = req_inbound_seq_value;
   assign push_item.test_id_present   = req_test_id_present;
   assign push_item.new_seq_present   = req_new_seq_present;
   assign push_item.new_seq_value     = req_new_seq_value;
   assign push_item.in_weekly_window  = req_in_weekly_window;

   fssh_inq #(
      .DEPTH (INQ_DEPTH)
   ) u_inq (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_item  (push_item),
      .full       (req_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .take       (take)
   );

   fssh_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_valid       (head_valid),
      .item             (head_item),
      .item_take        (take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result       (result)
   );

   assign rsp_event_kind    = result.event_kind;
   assign rsp_assigned_seq  = result.assigned_seq;
   assign rsp_expected_seq  = result.expected_seq;
   assign rsp_session_phase = result.session_phase;
   assign rsp_last_of_run   = result.last_of_run;

endmodule
